FILE: hdl/pll_divider_search_core_assert.svh
// assertion macros shared by the divider search rtl
// depends on nothing; included by the modules that carry checks
`ifndef PLL_DIVIDER_SEARCH_CORE_ASSERT_SVH
`define PLL_DIVIDER_SEARCH_CORE_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define PDSC_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("pdsc assertion failed");
`define PDSC_NEVER(lbl, clk, rst_n, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
		else $error("pdsc forbidden condition seen");
`else
`define PDSC_ASSERT(lbl, clk, rst_n, prop)
`define PDSC_NEVER(lbl, clk, rst_n, expr)
`endif

`endif

FILE: hdl/pdsc_pkg.sv
// types, constants and state encoding for the pll divider search
// depends on nothing
package pdsc_pkg;

	localparam int unsigned TGT_W          = 29;
	localparam int unsigned SYS_W          = 31;
	localparam int unsigned MAX_SAMPLE_DIV = 128;
	localparam int unsigned POST_DIV_MAX   = 7;
	localparam int unsigned DIV_W          = $clog2(MAX_SAMPLE_DIV + 1);
	localparam int unsigned POST_W         = $clog2(POST_DIV_MAX + 1);
	localparam int unsigned AB_W           = 2 * POST_W;
	localparam int unsigned TD_W           = TGT_W + DIV_W;
	localparam int unsigned WANT_W         = TD_W + AB_W;
	localparam int unsigned DEN_W          = SYS_W + DIV_W - 1;

	localparam int unsigned DEFAULT_SYS_I = 200000000;
	localparam int unsigned REF_I         = 12000000;
	localparam int unsigned REF_HALF_I    = 6000000;
	localparam int unsigned FB_MIN        = 16;
	localparam int unsigned FB_MAX        = 320;
	localparam int unsigned VCO_MIN       = 400000000;
	localparam int unsigned VCO_MAX       = 1600000000;

	// feedback divider window after both the divider and the vco limits
	localparam int unsigned FB_VLO = (VCO_MIN + REF_I - 1) / REF_I;
	localparam int unsigned FB_VHI = VCO_MAX / REF_I;
	localparam int unsigned FB_LO  = (FB_VLO > FB_MIN) ? FB_VLO : FB_MIN;
	localparam int unsigned FB_HI  = (FB_VHI < FB_MAX) ? FB_VHI : FB_MAX;

	localparam int unsigned FB_W       = $clog2(FB_HI + 1);
	localparam int unsigned LIM_STEPS  = $clog2(MAX_SAMPLE_DIV);
	localparam int unsigned FB_STEPS   = FB_W;
	localparam int unsigned WIDE_STEPS = SYS_W;
	localparam int unsigned CNT_W      = $clog2(WIDE_STEPS + 1);

	typedef logic [TGT_W-1:0]  tgt_t;
	typedef logic [SYS_W-1:0]  sys_t;
	typedef logic [SYS_W:0]    prod_t;
	typedef logic [DEN_W-1:0]  den_t;
	typedef logic [DEN_W:0]    den2_t;
	typedef logic [DIV_W-1:0]  dcnt_t;
	typedef logic [POST_W-1:0] post_t;
	typedef logic [AB_W-1:0]   ab_t;
	typedef logic [TD_W-1:0]   td_t;
	typedef logic [WANT_W-1:0] want_t;
	typedef logic [WANT_W:0]   sum_t;
	typedef logic [FB_W-1:0]   fb_t;
	typedef logic [CNT_W-1:0]  cnt_t;

	localparam sys_t  DEFAULT_SYS_HZ = sys_t'(DEFAULT_SYS_I);
	localparam sys_t  REF_HZ         = sys_t'(REF_I);
	localparam sum_t  REF_HALF_HZ    = sum_t'(REF_HALF_I);
	localparam sum_t  FB_LO_NUM      = sum_t'(FB_LO * REF_I);
	localparam sum_t  FB_END_NUM     = sum_t'((FB_HI + 1) * REF_I);
	localparam dcnt_t MAX_DIV        = dcnt_t'(MAX_SAMPLE_DIV);
	localparam post_t POST_MAX       = post_t'(POST_DIV_MAX);
	localparam cnt_t  LIM_CNT        = cnt_t'(LIM_STEPS);
	localparam cnt_t  FB_CNT         = cnt_t'(FB_STEPS);
	localparam cnt_t  WIDE_CNT       = cnt_t'(WIDE_STEPS);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_LIM,
		ST_LIM_W,
		ST_TD,
		ST_WANT,
		ST_CHK,
		ST_FB_W,
		ST_VCO,
		ST_SYS_W,
		ST_RATE_W,
		ST_CMP,
		ST_NEXT,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic start;
		sys_t num;
		den_t den_sh;
		cnt_t steps;
	} div_req_t;

	typedef struct packed {
		logic done;
		sys_t quo;
	} div_rsp_t;

endpackage

FILE: hdl/pdsc_intf.sv
// valid/ready channel interfaces for the divider search items
// depends on pdsc_pkg
interface pdsc_req_if;
	logic            valid;
	logic            ready;
	pdsc_pkg::tgt_t  target_hz;
	modport source(output valid, output target_hz, input ready);
	modport sink(input valid, input target_hz, output ready);
endinterface

interface pdsc_resp_if;
	logic            valid;
	logic            ready;
	pdsc_pkg::sys_t  best_sys_hz;
	modport source(output valid, output best_sys_hz, input ready);
	modport sink(input valid, input best_sys_hz, output ready);
endinterface

FILE: hdl/pll_divider_search_core.sv
// Top level of the pll divider search. One item is a wanted sample rate; the block walks
// the sample divider d (1 up to min(200M/target, 128)), then p1 and p2 (1..7) and returns
// the system clock of the first candidate with the smallest rate error, or 200 MHz when
// none fits. It takes one item at a time and drops ready until the result has been handed
// to the output register. Time per item is set by the single shared restoring divider,
// which gives one quotient bit per cycle. It divides 200M by the target for the bound
// when that is under 128; a candidate rejected by the feedback-divider and vco window
// needs no divide, and each usable candidate takes an 8-bit feedback divide, then
// 31-bit divides by p1*p2 and by d.
// An exact match ends the search early.
// depends on pdsc_pkg, pdsc_intf, pdsc_div, pdsc_ctrl

module pll_divider_search_core (
	input  logic         clk,
	input  logic         arst_n,
	pdsc_req_if.sink     req,
	pdsc_resp_if.source  resp
);

	pdsc_pkg::div_req_t div_req;
	pdsc_pkg::div_rsp_t div_rsp;
	logic               res_valid;
	pdsc_pkg::sys_t     res_sys_hz;
	logic               slot_free;
	logic               out_valid_q;
	pdsc_pkg::sys_t     out_sys_q;

	assign slot_free = !out_valid_q || resp.ready;

	pdsc_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (req.valid),
		.target_hz  (req.target_hz),
		.in_ready   (req.ready),
		.slot_free  (slot_free),
		.res_valid  (res_valid),
		.res_sys_hz (res_sys_hz),
		.div_req    (div_req),
		.div_rsp    (div_rsp)
	);

	pdsc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// output item register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid) begin
			out_valid_q <= 1'b1;
		end else if (resp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid) out_sys_q <= res_sys_hz;
	end

	assign resp.valid       = out_valid_q;
	assign resp.best_sys_hz = out_sys_q;

endmodule

FILE: hdl/pdsc_div.sv
// shared restoring divider, one quotient bit per cycle
// depends on pdsc_pkg and pll_divider_search_core_assert.svh
`include "pll_divider_search_core_assert.svh"

module pdsc_div (
	input  logic               clk,
	input  logic               arst_n,
	input  pdsc_pkg::div_req_t req,
	output pdsc_pkg::div_rsp_t rsp
);

	logic           busy_q;
	logic           done_q;
	pdsc_pkg::cnt_t cnt_q;
	pdsc_pkg::sys_t rem_q;
	pdsc_pkg::den_t dsh_q;
	pdsc_pkg::sys_t quo_q;
	pdsc_pkg::den_t rem_ext;
	pdsc_pkg::den2_t rem_ext2;
	pdsc_pkg::den2_t dsh_dbl;
	logic           ge;
	logic           last;

	assign rem_ext  = pdsc_pkg::den_t'(rem_q);
	assign rem_ext2 = pdsc_pkg::den2_t'(rem_q);
	assign dsh_dbl  = {dsh_q, 1'b0};
	assign ge       = rem_ext >= dsh_q;
	assign last     = busy_q && (cnt_q == pdsc_pkg::cnt_t'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= last && !req.start;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= req.steps;
			end else if (busy_q) begin
				cnt_q <= cnt_q - pdsc_pkg::cnt_t'(1);
				if (last) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= req.num;
			dsh_q <= req.den_sh;
			quo_q <= '0;
		end else if (busy_q) begin
			if (ge) begin
				rem_q <= rem_q - dsh_q[pdsc_pkg::SYS_W-1:0];
			end
			quo_q <= {quo_q[pdsc_pkg::SYS_W-2:0], ge};
			dsh_q <= dsh_q >> 1;
		end
	end

	assign rsp.done = done_q;
	assign rsp.quo  = quo_q;

	`PDSC_NEVER(a_start_busy, clk, arst_n, req.start && busy_q)
	`PDSC_ASSERT(a_rem_bound, clk, arst_n, busy_q |-> (rem_ext2 < dsh_dbl))
	`PDSC_ASSERT(a_done_idle, clk, arst_n, done_q |-> !busy_q)

endmodule

FILE: hdl/pdsc_ctrl.sv
// search sequencer: walks d, p1, p2 and keeps the best candidate
// depends on pdsc_pkg and pll_divider_search_core_assert.svh
`include "pll_divider_search_core_assert.svh"

module pdsc_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  pdsc_pkg::tgt_t     target_hz,
	output logic               in_ready,
	input  logic               slot_free,
	output logic               res_valid,
	output pdsc_pkg::sys_t     res_sys_hz,
	output pdsc_pkg::div_req_t div_req,
	input  pdsc_pkg::div_rsp_t div_rsp
);

	pdsc_pkg::state_t state_q;
	pdsc_pkg::state_t state_d;
	logic             have_q;

	pdsc_pkg::tgt_t   target_q;
	pdsc_pkg::dcnt_t  dlim_q;
	pdsc_pkg::dcnt_t  d_q;
	pdsc_pkg::post_t  a_q;
	pdsc_pkg::post_t  b_q;
	pdsc_pkg::td_t    td_q;
	pdsc_pkg::want_t  want_q;
	pdsc_pkg::fb_t    fb_q;
	pdsc_pkg::sys_t   sys_q;
	pdsc_pkg::sys_t   rate_q;
	pdsc_pkg::sys_t   best_sys_q;
	pdsc_pkg::sys_t   best_err_q;

	pdsc_pkg::ab_t    ab_c;
	pdsc_pkg::sum_t   sum_c;
	pdsc_pkg::prod_t  vco_c;
	pdsc_pkg::td_t    lim_chk;
	pdsc_pkg::sys_t   tgt_ext;
	pdsc_pkg::sys_t   err_c;
	logic             lim_sat;
	logic             cand_ok;
	logic             better;
	logic             last_b;
	logic             last_a;
	logic             last_d;

	assign ab_c    = pdsc_pkg::ab_t'(a_q) * pdsc_pkg::ab_t'(b_q);
	assign sum_c   = pdsc_pkg::sum_t'(want_q) + pdsc_pkg::REF_HALF_HZ;
	assign cand_ok = (sum_c >= pdsc_pkg::FB_LO_NUM) && (sum_c < pdsc_pkg::FB_END_NUM);
	assign vco_c   = pdsc_pkg::prod_t'(pdsc_pkg::REF_HZ) * pdsc_pkg::prod_t'(fb_q);
	assign lim_chk = pdsc_pkg::td_t'(target_q) * pdsc_pkg::td_t'(pdsc_pkg::MAX_DIV);
	assign lim_sat = (target_q == '0) ||
		(lim_chk <= pdsc_pkg::td_t'(pdsc_pkg::DEFAULT_SYS_HZ));
	assign tgt_ext = pdsc_pkg::sys_t'(target_q);
	assign err_c   = (rate_q > tgt_ext) ? (rate_q - tgt_ext) : (tgt_ext - rate_q);
	assign better  = !have_q || (err_c < best_err_q);
	assign last_b  = b_q == pdsc_pkg::POST_MAX;
	assign last_a  = a_q == pdsc_pkg::POST_MAX;
	assign last_d  = d_q == dlim_q;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			pdsc_pkg::ST_IDLE: begin
				if (in_valid) state_d = pdsc_pkg::ST_LIM;
			end
			pdsc_pkg::ST_LIM: begin
				state_d = lim_sat ? pdsc_pkg::ST_TD : pdsc_pkg::ST_LIM_W;
			end
			pdsc_pkg::ST_LIM_W: begin
				if (div_rsp.done) state_d = pdsc_pkg::ST_TD;
			end
			pdsc_pkg::ST_TD: begin
				state_d = pdsc_pkg::ST_WANT;
			end
			pdsc_pkg::ST_WANT: begin
				state_d = pdsc_pkg::ST_CHK;
			end
			pdsc_pkg::ST_CHK: begin
				state_d = cand_ok ? pdsc_pkg::ST_FB_W : pdsc_pkg::ST_NEXT;
			end
			pdsc_pkg::ST_FB_W: begin
				if (div_rsp.done) state_d = pdsc_pkg::ST_VCO;
			end
			pdsc_pkg::ST_VCO: begin
				state_d = pdsc_pkg::ST_SYS_W;
			end
			pdsc_pkg::ST_SYS_W: begin
				if (div_rsp.done) state_d = pdsc_pkg::ST_RATE_W;
			end
			pdsc_pkg::ST_RATE_W: begin
				if (div_rsp.done) state_d = pdsc_pkg::ST_CMP;
			end
			pdsc_pkg::ST_CMP: begin
				state_d = (better && (err_c == '0)) ? pdsc_pkg::ST_DONE : pdsc_pkg::ST_NEXT;
			end
			pdsc_pkg::ST_NEXT: begin
				if (last_b && last_a) begin
					state_d = last_d ? pdsc_pkg::ST_DONE : pdsc_pkg::ST_TD;
				end else begin
					state_d = pdsc_pkg::ST_WANT;
				end
			end
			pdsc_pkg::ST_DONE: begin
				if (slot_free) state_d = pdsc_pkg::ST_IDLE;
			end
			default: state_d = pdsc_pkg::ST_IDLE;
		endcase
	end

	// outputs and divider requests
	always_comb begin
		in_ready       = 1'b0;
		res_valid      = 1'b0;
		div_req.start  = 1'b0;
		div_req.num    = pdsc_pkg::DEFAULT_SYS_HZ;
		div_req.den_sh = pdsc_pkg::den_t'(target_q) << (pdsc_pkg::LIM_STEPS - 1);
		div_req.steps  = pdsc_pkg::LIM_CNT;
		unique case (state_q)
			pdsc_pkg::ST_IDLE: begin
				in_ready = 1'b1;
			end
			pdsc_pkg::ST_LIM: begin
				div_req.start = !lim_sat;
			end
			pdsc_pkg::ST_CHK: begin
				div_req.start  = cand_ok;
				div_req.num    = sum_c[pdsc_pkg::SYS_W-1:0];
				div_req.den_sh = pdsc_pkg::den_t'(pdsc_pkg::REF_HZ) << (pdsc_pkg::FB_STEPS - 1);
				div_req.steps  = pdsc_pkg::FB_CNT;
			end
			pdsc_pkg::ST_VCO: begin
				div_req.start  = 1'b1;
				div_req.num    = vco_c[pdsc_pkg::SYS_W-1:0];
				div_req.den_sh = pdsc_pkg::den_t'(ab_c) << (pdsc_pkg::WIDE_STEPS - 1);
				div_req.steps  = pdsc_pkg::WIDE_CNT;
			end
			pdsc_pkg::ST_SYS_W: begin
				div_req.start  = div_rsp.done;
				div_req.num    = div_rsp.quo;
				div_req.den_sh = pdsc_pkg::den_t'(d_q) << (pdsc_pkg::WIDE_STEPS - 1);
				div_req.steps  = pdsc_pkg::WIDE_CNT;
			end
			pdsc_pkg::ST_DONE: begin
				res_valid = slot_free;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pdsc_pkg::ST_IDLE;
			have_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == pdsc_pkg::ST_IDLE) begin
				have_q <= 1'b0;
			end else if (state_q == pdsc_pkg::ST_CMP && better) begin
				have_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			pdsc_pkg::ST_IDLE: begin
				if (in_valid) begin
					target_q   <= target_hz;
					d_q        <= pdsc_pkg::dcnt_t'(1);
					a_q        <= pdsc_pkg::post_t'(1);
					b_q        <= pdsc_pkg::post_t'(1);
					dlim_q     <= pdsc_pkg::MAX_DIV;
					best_sys_q <= pdsc_pkg::DEFAULT_SYS_HZ;
				end
			end
			pdsc_pkg::ST_LIM_W: begin
				if (div_rsp.done) begin
					dlim_q <= (div_rsp.quo == '0) ? pdsc_pkg::dcnt_t'(1)
						: div_rsp.quo[pdsc_pkg::DIV_W-1:0];
				end
			end
			pdsc_pkg::ST_TD: begin
				td_q <= pdsc_pkg::td_t'(target_q) * pdsc_pkg::td_t'(d_q);
			end
			pdsc_pkg::ST_WANT: begin
				want_q <= pdsc_pkg::want_t'(td_q) * pdsc_pkg::want_t'(ab_c);
			end
			pdsc_pkg::ST_FB_W: begin
				if (div_rsp.done) fb_q <= div_rsp.quo[pdsc_pkg::FB_W-1:0];
			end
			pdsc_pkg::ST_SYS_W: begin
				if (div_rsp.done) sys_q <= div_rsp.quo;
			end
			pdsc_pkg::ST_RATE_W: begin
				if (div_rsp.done) rate_q <= div_rsp.quo;
			end
			pdsc_pkg::ST_CMP: begin
				if (better) begin
					best_err_q <= err_c;
					best_sys_q <= sys_q;
				end
			end
			pdsc_pkg::ST_NEXT: begin
				if (last_b) begin
					b_q <= pdsc_pkg::post_t'(1);
					if (last_a) begin
						a_q <= pdsc_pkg::post_t'(1);
						d_q <= d_q + pdsc_pkg::dcnt_t'(1);
					end else begin
						a_q <= a_q + pdsc_pkg::post_t'(1);
					end
				end else begin
					b_q <= b_q + pdsc_pkg::post_t'(1);
				end
			end
			default: begin
			end
		endcase
	end

	assign res_sys_hz = best_sys_q;

	`PDSC_NEVER(a_post_zero, clk, arst_n,
		(state_q == pdsc_pkg::ST_CMP) && ((a_q == '0) || (b_q == '0) || (d_q == '0)))
	`PDSC_ASSERT(a_fb_window, clk, arst_n, (state_q == pdsc_pkg::ST_VCO) |->
		((fb_q >= pdsc_pkg::fb_t'(pdsc_pkg::FB_LO)) && (fb_q <= pdsc_pkg::fb_t'(pdsc_pkg::FB_HI))))
	`PDSC_ASSERT(a_d_bound, clk, arst_n, (state_q == pdsc_pkg::ST_CMP) |-> (d_q <= dlim_q))
	`PDSC_ASSERT(a_res_slot, clk, arst_n, res_valid |=> (state_q == pdsc_pkg::ST_IDLE))

endmodule
